// ----- sv/spq_pkg.sv -----
// Shared types, codes and defaults for the sorted priority queue.
// Depends on nothing; every other file of the block imports it.
package spq_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 16;

   localparam int         DATA_W     = 32;
   localparam int         CAP_W      = 5;
   localparam int         COUNT_OUT_W = 5;
   localparam int         CSR_ADDR_W = 3;
   localparam int         CSR_DATA_W = 32;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [0:0] CSR_IDX_QUEUE_CAPACITY = 1'b0;

   localparam logic [1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [1:0] MODE_DEQUEUE = 2'd1;
   localparam logic [1:0] MODE_CLEAR   = 2'd2;

   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_FULL_DROP  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY_DEQ  = 2'd2;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic commit;
   } dp_cmd_type;

endpackage

// ----- sv/spq_csr.sv -----
// Configuration register file of the sorted priority queue (APB-style).
// Depends on spq_pkg.
module spq_csr
   import spq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [CAP_W-1:0]      queue_capacity
);

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic             sel_capacity;

   assign pready       = 1'b1;
   assign sel_capacity = (paddr[2] == CSR_IDX_QUEUE_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && pready && sel_capacity) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata         = sel_capacity ? {{(CSR_DATA_W-CAP_W){1'b0}}, capacity_ff}
                                        : '0;
   assign queue_capacity = capacity_ff;

endmodule

// ----- sv/spq_ctrl.sv -----
// Controller of the sorted priority queue: request sequencing and result valid.
// Depends on spq_pkg.
module spq_ctrl
   import spq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EXEC: begin
            cmd.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/spq_dpath.sv -----
// Datapath of the sorted priority queue: request latch, sorted cell array with
// parallel compare and shift, entry count and result register. Depends on spq_pkg.
module spq_dpath
   import spq_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  logic [CAP_W-1:0]         queue_capacity,
   input  logic [1:0]               req_mode,
   input  logic signed [DATA_W-1:0] req_item_data,
   input  logic signed [DATA_W-1:0] req_item_priority,
   output logic [1:0]               rsp_status,
   output logic                     rsp_head_valid,
   output logic signed [DATA_W-1:0] rsp_head_data,
   output logic signed [DATA_W-1:0] rsp_head_priority,
   output logic [COUNT_OUT_W-1:0]   rsp_entry_count,
   output logic                     rsp_is_full,
   output logic                     rsp_is_empty
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = CW + CAP_W;

   logic [1:0]               mode_ff;
   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] prio_ff;

   logic signed [DATA_W-1:0] cell_data_ff [MAX_ENTRIES];
   logic signed [DATA_W-1:0] cell_prio_ff [MAX_ENTRIES];
   logic signed [DATA_W-1:0] cell_data_in [MAX_ENTRIES];
   logic signed [DATA_W-1:0] cell_prio_in [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]   ge;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [IW-1:0] count_ext;
   logic [IW-1:0] count_new_ext;
   logic [IW-1:0] cap_ext;
   logic [IW-1:0] max_ext;
   logic [IW-1:0] cap_eff;
   logic          full_now;
   logic          empty_now;
   logic          enq_ok;
   logic [1:0]    status_in;

   logic [1:0]               status_ff;
   logic                     head_valid_ff;
   logic signed [DATA_W-1:0] head_data_ff;
   logic signed [DATA_W-1:0] head_prio_ff;
   logic [COUNT_OUT_W-1:0]   entry_count_ff;
   logic                     is_full_ff;
   logic                     is_empty_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         data_ff <= req_item_data;
         prio_ff <= req_item_priority;
      end
   end

   assign count_ext = {{CAP_W{1'b0}}, count_ff};
   assign cap_ext   = {{CW{1'b0}}, queue_capacity};
   assign max_ext   = IW'(MAX_ENTRIES);
   assign cap_eff   = (cap_ext > max_ext) ? max_ext : cap_ext;
   assign full_now  = (count_ext >= cap_eff);
   assign empty_now = (count_ff == '0);
   assign enq_ok    = (mode_ff == MODE_ENQUEUE) && !full_now;

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      assign ge[g] = (CW'(g) < count_ff) && (cell_prio_ff[g] >= prio_ff);

      always_comb begin
         cell_data_in[g] = cell_data_ff[g];
         cell_prio_in[g] = cell_prio_ff[g];
         case (mode_ff)
            MODE_ENQUEUE: begin
               if (!full_now && !ge[g]) begin
                  if (g == 0) begin
                     cell_data_in[g] = data_ff;
                     cell_prio_in[g] = prio_ff;
                  end else if (ge[(g == 0) ? 0 : g-1]) begin
                     cell_data_in[g] = data_ff;
                     cell_prio_in[g] = prio_ff;
                  end else begin
                     cell_data_in[g] = cell_data_ff[(g == 0) ? 0 : g-1];
                     cell_prio_in[g] = cell_prio_ff[(g == 0) ? 0 : g-1];
                  end
               end
            end
            MODE_DEQUEUE: begin
               if (!empty_now && (g != MAX_ENTRIES-1)) begin
                  cell_data_in[g] = cell_data_ff[(g == MAX_ENTRIES-1) ? g : g+1];
                  cell_prio_in[g] = cell_prio_ff[(g == MAX_ENTRIES-1) ? g : g+1];
               end
            end
            default: begin
               cell_data_in[g] = cell_data_ff[g];
            end
         endcase
      end

      always_ff @(posedge clock) begin
         if (cmd.commit) begin
            cell_data_ff[g] <= cell_data_in[g];
            cell_prio_ff[g] <= cell_prio_in[g];
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_DONE;
      case (mode_ff)
         MODE_ENQUEUE: begin
            if (enq_ok) count_in = count_ff + CW'(1);
            else        status_in = STATUS_FULL_DROP;
         end
         MODE_DEQUEUE: begin
            if (!empty_now) count_in = count_ff - CW'(1);
            else            status_in = STATUS_EMPTY_DEQ;
         end
         MODE_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign count_new_ext = {{CAP_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff      <= status_in;
         head_valid_ff  <= (count_in != '0);
         head_data_ff   <= (count_in != '0) ? cell_data_in[0] : '0;
         head_prio_ff   <= (count_in != '0) ? cell_prio_in[0] : '0;
         entry_count_ff <= count_new_ext[COUNT_OUT_W-1:0];
         is_full_ff     <= (count_new_ext >= cap_eff);
         is_empty_ff    <= (count_in == '0);
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_head_valid    = head_valid_ff;
   assign rsp_head_data     = head_data_ff;
   assign rsp_head_priority = head_prio_ff;
   assign rsp_entry_count   = entry_count_ff;
   assign rsp_is_full       = is_full_ff;
   assign rsp_is_empty      = is_empty_ff;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// Sorted priority queue, highest priority first, first in first out among equals.
// Each item first has its request latched; then all cells compare against the
// new priority and shift in parallel while the result register loads; the next
// item is accepted while that result waits, and a result that is still waiting
// holds the compare and shift step. Results come one per item, in order.
// Top level; depends on spq_pkg, spq_csr, spq_ctrl and spq_dpath.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_mode,
   input  logic signed [DATA_W-1:0] req_item_data,
   input  logic signed [DATA_W-1:0] req_item_priority,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic                     rsp_head_valid,
   output logic signed [DATA_W-1:0] rsp_head_data,
   output logic signed [DATA_W-1:0] rsp_head_priority,
   output logic [COUNT_OUT_W-1:0]   rsp_entry_count,
   output logic                     rsp_is_full,
   output logic                     rsp_is_empty,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready
);

   dp_cmd_type       cmd;
   logic [CAP_W-1:0] queue_capacity;

   spq_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .queue_capacity (queue_capacity)
   );

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spq_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .queue_capacity    (queue_capacity),
      .req_mode          (req_mode),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_status        (rsp_status),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_data     (rsp_head_data),
      .rsp_head_priority (rsp_head_priority),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_full       (rsp_is_full),
      .rsp_is_empty      (rsp_is_empty)
   );

endmodule

// ----- verif/tb_sorted_priority_queue.sv -----
// Self-checking testbench for sorted_priority_queue: directed and random queue
// operations, with the capacity register changed over APB between batches.
// Depends on spq_pkg and the sorted_priority_queue RTL only.
module tb_sorted_priority_queue
   import spq_pkg::*;
();

   localparam int DEPTH       = DEFAULT_MAX_ENTRIES;
   localparam int IDLE_PCT    = 15;
   localparam int STALL_LIMIT = 2000;
   localparam int NUM_BATCHES = 9;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CAPACITY =
      CSR_ADDR_W'(int'(CSR_IDX_QUEUE_CAPACITY) * 4);

   localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] ALL_ONES = '1;

   // capacity -1 picks a random setting
   localparam int BATCH_CAP [NUM_BATCHES]   = '{31, 5, 0, 1, 16, 8, 2, 17, -1};
   localparam int BATCH_ITEMS [NUM_BATCHES] = '{200, 150, 60, 150, 250, 200, 150, 200, 240};
   localparam int BATCH_ENQ [NUM_BATCHES]   = '{70, 50, 50, 55, 60, 65, 50, 62, 60};
   localparam int STEADY_BATCH = 4;

   typedef struct {
      logic [1:0]               mode;
      logic signed [DATA_W-1:0] data;
      logic signed [DATA_W-1:0] prio;
   } queue_op_type;

   typedef struct {
      logic [1:0]               status;
      logic                     head_valid;
      logic signed [DATA_W-1:0] head_data;
      logic signed [DATA_W-1:0] head_prio;
      logic [COUNT_OUT_W-1:0]   count;
      logic                     full;
      logic                     empty;
   } head_report_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_mode = MODE_ENQUEUE;
   logic signed [DATA_W-1:0] req_item_data = '0;
   logic signed [DATA_W-1:0] req_item_priority = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_status;
   logic                     rsp_head_valid;
   logic signed [DATA_W-1:0] rsp_head_data;
   logic signed [DATA_W-1:0] rsp_head_priority;
   logic [COUNT_OUT_W-1:0]   rsp_entry_count;
   logic                     rsp_is_full;
   logic                     rsp_is_empty;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    paddr = '0;
   logic [CSR_DATA_W-1:0]    pwdata = '0;
   logic [CSR_DATA_W-1:0]    prdata;
   logic                     pready;

   queue_op_type    pending_ops[$];
   head_report_type expected_heads[$];
   head_report_type want;
   queue_op_type    next_op;

   logic signed [DATA_W-1:0] shadow_data [DEPTH];
   logic signed [DATA_W-1:0] shadow_prio [DEPTH];
   int                       shadow_count = 0;
   logic [CAP_W-1:0]         shadow_capacity = CAP_RESET;

   logic steady = 1'b0;
   int   mismatch_count = 0;
   int   quiet_cycles = 0;

   sorted_priority_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_data     (rsp_head_data),
      .rsp_head_priority (rsp_head_priority),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_full       (rsp_is_full),
      .rsp_is_empty      (rsp_is_empty),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic head_report_type apply_queue_op(input queue_op_type op);
      head_report_type r;
      int limit;
      int pos;
      limit = (shadow_capacity > DEPTH) ? DEPTH : int'(shadow_capacity);
      r.status = STATUS_DONE;
      case (op.mode)
         MODE_ENQUEUE: begin
            if (shadow_count >= limit) begin
               r.status = STATUS_FULL_DROP;
            end else begin
               pos = 0;
               while (pos < shadow_count && shadow_prio[pos] >= op.prio) pos++;
               for (int k = shadow_count; k > pos; k--) begin
                  shadow_data[k] = shadow_data[k-1];
                  shadow_prio[k] = shadow_prio[k-1];
               end
               shadow_data[pos] = op.data;
               shadow_prio[pos] = op.prio;
               shadow_count++;
            end
         end
         MODE_DEQUEUE: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY_DEQ;
            end else begin
               for (int k = 0; k + 1 < shadow_count; k++) begin
                  shadow_data[k] = shadow_data[k+1];
                  shadow_prio[k] = shadow_prio[k+1];
               end
               shadow_count--;
            end
         end
         MODE_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      r.head_valid = (shadow_count != 0);
      r.head_data  = (shadow_count != 0) ? shadow_data[0] : '0;
      r.head_prio  = (shadow_count != 0) ? shadow_prio[0] : '0;
      r.count      = COUNT_OUT_W'(shadow_count);
      r.full       = (shadow_count >= limit);
      r.empty      = (shadow_count == 0);
      return r;
   endfunction

   task automatic check_field(input string label, input logic [DATA_W-1:0] exp_val,
                              input logic [DATA_W-1:0] got_val);
      if (got_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, label, exp_val, got_val);
         mismatch_count++;
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            next_op.mode = req_mode;
            next_op.data = req_item_data;
            next_op.prio = req_item_priority;
            expected_heads.push_back(apply_queue_op(next_op));
         end
         if (!req_valid || req_ready) begin
            if (pending_ops.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               next_op = pending_ops.pop_front();
               req_valid         <= 1'b1;
               req_mode          <= next_op.mode;
               req_item_data     <= next_op.data;
               req_item_priority <= next_op.prio;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_heads.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0h count %0d",
                        $time, rsp_status, rsp_entry_count);
               mismatch_count++;
            end else begin
               want = expected_heads.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("head_valid", want.head_valid, rsp_head_valid);
               check_field("head_data", want.head_data, rsp_head_data);
               check_field("head_priority", want.head_prio, rsp_head_priority);
               check_field("entry_count", want.count, rsp_entry_count);
               check_field("is_full", want.full, rsp_is_full);
               check_field("is_empty", want.empty, rsp_is_empty);
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("tb_sorted_priority_queue NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void add_op(input logic [1:0] mode, input logic signed [DATA_W-1:0] data,
                                  input logic signed [DATA_W-1:0] prio);
      queue_op_type op;
      op.mode = mode;
      op.data = data;
      op.prio = prio;
      pending_ops.push_back(op);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_priority();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1) ? MOST_POS : MOST_NEG;
         default: return $signed(DATA_W'($urandom_range(6))) - 3;
      endcase
   endfunction

   task automatic drain();
      while (pending_ops.size() != 0 || req_valid || expected_heads.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_capacity(input logic [CAP_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_CAPACITY;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      shadow_capacity = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      check_field("queue_capacity readback", value, prdata[CAP_W-1:0]);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic random_batch(input int count, input int enq_pct);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < enq_pct)
            add_op(MODE_ENQUEUE, $urandom, pick_priority());
         else if (pick < 95)
            add_op(MODE_DEQUEUE, $urandom, $urandom);
         else if (pick < 98)
            add_op(MODE_CLEAR, $urandom, $urandom);
         else
            add_op(MODE_UNUSED, $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: empty cases, extremes, ties, clear
      add_op(MODE_DEQUEUE, '0, '0);
      add_op(MODE_UNUSED, ALL_ONES, ALL_ONES);
      add_op(MODE_ENQUEUE, MOST_POS, MOST_NEG);
      add_op(MODE_ENQUEUE, MOST_NEG, MOST_POS);
      add_op(MODE_ENQUEUE, '0, '0);
      add_op(MODE_ENQUEUE, ALL_ONES, '0);
      add_op(MODE_ENQUEUE, 1, ALL_ONES);
      add_op(MODE_UNUSED, '0, '0);
      add_op(MODE_DEQUEUE, ALL_ONES, ALL_ONES);
      add_op(MODE_DEQUEUE, '0, '0);
      add_op(MODE_CLEAR, ALL_ONES, ALL_ONES);
      add_op(MODE_DEQUEUE, '0, '0);
      drain();

      // small capacity: fill, drop, drain past empty
      program_capacity(CAP_W'(2));
      add_op(MODE_ENQUEUE, 10, 5);
      add_op(MODE_ENQUEUE, 11, 5);
      add_op(MODE_ENQUEUE, 12, 9);
      add_op(MODE_DEQUEUE, '0, '0);
      add_op(MODE_DEQUEUE, '0, '0);
      add_op(MODE_DEQUEUE, '0, '0);
      drain();

      // zero capacity
      program_capacity(CAP_W'(0));
      add_op(MODE_ENQUEUE, MOST_POS, MOST_POS);
      add_op(MODE_CLEAR, '0, '0);
      drain();

      for (int b = 0; b < NUM_BATCHES; b++) begin
         program_capacity(BATCH_CAP[b] < 0 ? CAP_W'($urandom_range(31)) : CAP_W'(BATCH_CAP[b]));
         steady <= (b == STEADY_BATCH);
         random_batch(BATCH_ITEMS[b], BATCH_ENQ[b]);
         drain();
      end
      steady <= 1'b0;
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb_sorted_priority_queue OK");
      else
         $display("tb_sorted_priority_queue NOT OK");
      $finish;
   end

endmodule
